>>> rtl/lobm_pkg.sv
// Shared types and codes for the limit order book matcher.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package lobm_pkg;

  // Final status carried on the last result of an order.
  typedef enum logic [1:0] {
    OUT_FILLED   = 2'd0,
    OUT_RESTED   = 2'd1,
    OUT_REJECTED = 2'd2,
    OUT_ZERO     = 2'd3
  } outcome_t;

  // Incoming order after classification by the front end.
  typedef struct packed {
    logic        side;
    logic [7:0]  tick;
    logic [30:0] qty;
    logic [31:0] id;
    logic [31:0] time_stamp;
    logic        zero_qty;
  } order_t;

  // One result item.
  typedef struct packed {
    logic        is_trade;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [7:0]  fill_tick;
    logic [30:0] fill_quantity;
    logic [31:0] fill_time;
    logic [30:0] left_over;
    outcome_t    outcome;
    logic        last;
  } result_t;

  // Matcher sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HEAD,
    ST_SLOT,
    ST_REST,
    ST_PLACE,
    ST_LINK,
    ST_DONE
  } mstate_t;

endpackage
`default_nettype wire

>>> rtl/limit_order_book_matcher.sv
// Top level of the limit order book matcher: front end, order queue, matcher.
// Depends on lobm_pkg, lobm_front, lobm_queue and lobm_back.
//
// Usage. An order request enters on in_valid/in_ready with its side, limit
// tick, quantity, id and arrival time. Results leave on out_valid/out_ready,
// one per fill, with the final status and the last flag riding on the final
// fill. An order that fills nothing gives one non-trade result; a zero
// quantity gives one result with the zero-quantity status and leaves the book
// untouched.
// Flow. The front end registers and classifies a request and a two-entry
// queue decouples it from the matcher, which takes a new order only when idle.
// The matcher loads an order and scans the opposite side one sixteen-level
// chunk at a time. For each fill after the chunk that finds the level it reads
// the head, then reads and updates the slot, waiting while the output register
// holds an unaccepted result. It rests a remainder in a rest and a place step,
// plus a link step on a level that already holds orders, and then hands over
// the final result.
// Reset. A synchronous active-high reset empties the book and the queue and
// returns every order slot to the free pool; no clearing pass is needed.
// Stalls. Results are held in an output register; when the receiver stalls,
// the matcher waits on its next result and the queue then fills and the front
// end deasserts in_ready.
`default_nettype none
module limit_order_book_matcher #(
  parameter int PRICE_LEVELS = 256,
  parameter int ORDER_SLOTS  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        side,
  input  wire logic [7:0]  limit_tick,
  input  wire logic [30:0] order_quantity,
  input  wire logic [31:0] incoming_id,
  input  wire logic [31:0] arrival_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_trade,
  output logic [31:0]      buyer_id,
  output logic [31:0]      seller_id,
  output logic [7:0]       fill_tick,
  output logic [30:0]      fill_quantity,
  output logic [31:0]      fill_time,
  output logic [30:0]      left_over,
  output logic [1:0]       outcome,
  output logic             last
);

  logic              f_valid;
  logic              f_ready;
  lobm_pkg::order_t  f_item;
  logic              q_valid;
  logic              q_ready;
  lobm_pkg::order_t  q_item;
  lobm_pkg::result_t res;

  lobm_front #(.PRICE_LEVELS(PRICE_LEVELS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .side           (side),
    .limit_tick     (limit_tick),
    .order_quantity (order_quantity),
    .incoming_id    (incoming_id),
    .arrival_time   (arrival_time),
    .item_valid     (f_valid),
    .item           (f_item),
    .item_ready     (f_ready)
  );

  lobm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_item),
    .rd_valid (q_valid),
    .rd_data  (q_item),
    .rd_ready (q_ready)
  );

  lobm_back #(
    .PRICE_LEVELS (PRICE_LEVELS),
    .ORDER_SLOTS  (ORDER_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_data   (res),
    .out_ready  (out_ready)
  );

  assign is_trade      = res.is_trade;
  assign buyer_id      = res.buyer_id;
  assign seller_id     = res.seller_id;
  assign fill_tick     = res.fill_tick;
  assign fill_quantity = res.fill_quantity;
  assign fill_time     = res.fill_time;
  assign left_over     = res.left_over;
  assign outcome       = res.outcome;
  assign last          = res.last;

endmodule
`default_nettype wire

>>> rtl/lobm_front.sv
// Front end of the matcher: registers an incoming order, clamps its tick to the
// book and flags a zero quantity. Depends on lobm_pkg.
`default_nettype none
module lobm_front #(
  parameter int PRICE_LEVELS = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            side,
  input  wire logic [7:0]      limit_tick,
  input  wire logic [30:0]     order_quantity,
  input  wire logic [31:0]     incoming_id,
  input  wire logic [31:0]     arrival_time,
  output logic                 item_valid,
  output lobm_pkg::order_t     item,
  input  wire logic            item_ready
);

  lobm_pkg::order_t cls;

  always_comb begin
    cls.side       = side;
    cls.tick       = (int'(limit_tick) >= PRICE_LEVELS) ? 8'(PRICE_LEVELS - 1) : limit_tick;
    cls.qty        = order_quantity;
    cls.id         = incoming_id;
    cls.time_stamp = arrival_time;
    cls.zero_qty   = (order_quantity == '0);
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= cls;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lobm_queue.sv
// Two-entry queue of classified orders between the front end and the matcher.
// Depends on lobm_pkg.
`default_nettype none
module lobm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire lobm_pkg::order_t wr_data,
  output logic                 rd_valid,
  output lobm_pkg::order_t     rd_data,
  input  wire logic            rd_ready
);

  lobm_pkg::order_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lobm_back.sv
// Matching engine: scans the opposite side for the best level, fills against
// resting orders oldest first, and rests any remainder while a free slot is left. Depends on lobm_pkg.
`default_nettype none
module lobm_back #(
  parameter int PRICE_LEVELS = 256,
  parameter int ORDER_SLOTS  = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire lobm_pkg::order_t item,
  output logic                  out_valid,
  output lobm_pkg::result_t     out_data,
  input  wire logic             out_ready
);

  localparam int CH  = (PRICE_LEVELS < 16) ? (2 ** $clog2(PRICE_LEVELS)) : 16;
  localparam int OW  = $clog2(CH);
  localparam int NCH = (PRICE_LEVELS + CH - 1) / CH;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int XW  = $clog2(2 * PRICE_LEVELS);
  localparam int SW  = $clog2(ORDER_SLOTS);
  localparam int NL  = 2 * PRICE_LEVELS;

  // Storage.
  logic [31:0]   slot_owner [ORDER_SLOTS];
  logic [30:0]   slot_qty   [ORDER_SLOTS];
  logic [SW-1:0] slot_link  [ORDER_SLOTS];
  logic [SW-1:0] lvl_head   [NL];
  logic [SW-1:0] lvl_tail   [NL];
  logic [SW-1:0] free_stack [ORDER_SLOTS];
  logic [NL-1:0] nonempty;
  logic [SW:0]   free_cnt;
  logic [SW:0]   low_mark;

  // Registered read data.
  logic [SW-1:0] head_q;
  logic [SW-1:0] tail_q;
  logic [31:0]   owner_q;
  logic [30:0]   qty_q;
  logic [SW-1:0] link_q;
  logic [SW-1:0] stack_q;

  // Control and working registers.
  lobm_pkg::mstate_t  state;
  lobm_pkg::mstate_t  state_next;
  lobm_pkg::order_t   cur;
  lobm_pkg::result_t  pend;
  lobm_pkg::outcome_t res_code;
  logic               have_pend;
  logic [30:0]        rem;
  logic [CW-1:0]      chunk;
  logic [XW-1:0]      lv_hit;
  logic [7:0]         t_hit;
  logic [SW-1:0]      new_slot;

  // Combinational helpers.
  logic [NCH*CH-1:0]  pad;
  logic [CH-1:0]      bits;
  logic               found;
  logic [OW-1:0]      off_hit;
  logic               last_chunk;
  logic [XW-1:0]      scan_lv;
  logic [XW-1:0]      own_lv;
  logic [30:0]        fill;
  logic [30:0]        rem_new;
  logic [30:0]        qty_new;
  logic               step_ok;
  logic               out_free;
  logic               out_load;
  logic [SW-1:0]      pop_idx;
  logic [SW-1:0]      pop_slot;
  lobm_pkg::result_t  trade;
  lobm_pkg::result_t  final_res;

  // Memory write controls.
  logic          head_we;
  logic [XW-1:0] head_wa;
  logic [SW-1:0] head_wd;
  logic          tail_we;
  logic          qty_we;
  logic [SW-1:0] qty_wa;
  logic [30:0]   qty_wd;
  logic          own_we;
  logic          link_we;
  logic [SW-1:0] link_wa;
  logic          push_we;

  assign out_free = !out_valid || out_ready;

  // The output register takes a new result when a fill hands over the
  // previous one or when the final result leaves.
  assign out_load = ((state == lobm_pkg::ST_SLOT) && step_ok && have_pend) ||
                    ((state == lobm_pkg::ST_DONE) && out_free);

  // Level scan over one chunk of the opposite side.
  always_comb begin
    int base;
    int idx;
    pad = '0;
    pad[PRICE_LEVELS-1:0] = nonempty[(cur.side ? 0 : PRICE_LEVELS) +: PRICE_LEVELS];
    bits    = pad[int'(chunk) * CH +: CH];
    found   = 1'b0;
    off_hit = '0;
    base    = int'(chunk) * CH;
    if (!cur.side) begin
      for (int o = CH - 1; o >= 0; o--) begin
        idx = base + o;
        if (bits[o] && idx <= int'(cur.tick)) begin
          found   = 1'b1;
          off_hit = OW'(o);
        end
      end
    end else begin
      for (int o = 0; o < CH; o++) begin
        idx = base + o;
        if (bits[o] && idx >= int'(cur.tick)) begin
          found   = 1'b1;
          off_hit = OW'(o);
        end
      end
    end
    last_chunk = (int'(chunk) == (int'(cur.tick) >> OW));
    scan_lv    = XW'((cur.side ? 0 : PRICE_LEVELS) + base + int'(off_hit));
    own_lv     = XW'((cur.side ? PRICE_LEVELS : 0) + int'(cur.tick));
  end

  // Fill arithmetic and result building.
  always_comb begin
    fill    = (rem < qty_q) ? rem : qty_q;
    rem_new = rem - fill;
    qty_new = qty_q - fill;
    step_ok = !have_pend || out_free;
    pop_idx = SW'(free_cnt - 1'b1);
    pop_slot = ({1'b0, pop_idx} >= low_mark) ? stack_q : (SW'(ORDER_SLOTS - 1) - pop_idx);

    trade.is_trade      = 1'b1;
    trade.buyer_id      = cur.side ? owner_q : cur.id;
    trade.seller_id     = cur.side ? cur.id : owner_q;
    trade.fill_tick     = t_hit;
    trade.fill_quantity = fill;
    trade.fill_time     = cur.time_stamp;
    trade.left_over     = rem_new;
    trade.outcome       = lobm_pkg::OUT_FILLED;
    trade.last          = 1'b0;

    if (have_pend) begin
      final_res = pend;
    end else begin
      final_res               = '0;
      final_res.left_over     = rem;
    end
    final_res.outcome = res_code;
    final_res.last    = 1'b1;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lobm_pkg::ST_IDLE: begin
        if (item_valid) state_next = item.zero_qty ? lobm_pkg::ST_DONE : lobm_pkg::ST_SCAN;
      end
      lobm_pkg::ST_SCAN: begin
        priority if (found)      state_next = lobm_pkg::ST_HEAD;
        else if (last_chunk)     state_next = lobm_pkg::ST_REST;
      end
      lobm_pkg::ST_HEAD: state_next = lobm_pkg::ST_SLOT;
      lobm_pkg::ST_SLOT: begin
        if (step_ok) state_next = (rem_new == '0) ? lobm_pkg::ST_DONE : lobm_pkg::ST_SCAN;
      end
      lobm_pkg::ST_REST: begin
        state_next = (free_cnt == '0) ? lobm_pkg::ST_DONE : lobm_pkg::ST_PLACE;
      end
      lobm_pkg::ST_PLACE: state_next = nonempty[own_lv] ? lobm_pkg::ST_LINK : lobm_pkg::ST_DONE;
      lobm_pkg::ST_LINK:  state_next = lobm_pkg::ST_DONE;
      lobm_pkg::ST_DONE: begin
        if (out_free) state_next = lobm_pkg::ST_IDLE;
      end
      default: state_next = lobm_pkg::ST_IDLE;
    endcase
  end

  // Memory write strobes.
  always_comb begin
    item_ready = (state == lobm_pkg::ST_IDLE);
    head_we = 1'b0;
    head_wa = own_lv;
    head_wd = pop_slot;
    tail_we = 1'b0;
    qty_we  = 1'b0;
    qty_wa  = pop_slot;
    qty_wd  = rem;
    own_we  = 1'b0;
    link_we = 1'b0;
    link_wa = pop_slot;
    push_we = 1'b0;
    unique case (state)
      lobm_pkg::ST_SLOT: begin
        if (step_ok) begin
          qty_we = 1'b1;
          qty_wa = head_q;
          qty_wd = qty_new;
          if (qty_new == '0) begin
            push_we = (free_cnt < (SW + 1)'(ORDER_SLOTS));
            if (head_q != tail_q) begin
              head_we = 1'b1;
              head_wa = lv_hit;
              head_wd = link_q;
            end
          end
        end
      end
      lobm_pkg::ST_PLACE: begin
        qty_we  = 1'b1;
        own_we  = 1'b1;
        link_we = 1'b1;
        tail_we = 1'b1;
        head_we = !nonempty[own_lv];
      end
      lobm_pkg::ST_LINK: begin
        link_we = 1'b1;
        link_wa = tail_q;
      end
      default: ;
    endcase
  end

  // Memories. While a remainder is placed, the tail read stays on the own
  // level so that the link step sees the old tail.
  always_ff @(posedge clk) begin
    if (head_we) lvl_head[head_wa] <= head_wd;
    if (tail_we) lvl_tail[own_lv] <= pop_slot;
    if (qty_we)  slot_qty[qty_wa] <= qty_wd;
    if (own_we)  slot_owner[pop_slot] <= cur.id;
    if (link_we) slot_link[link_wa] <= (state == lobm_pkg::ST_LINK) ? new_slot : pop_slot;
    if (push_we) free_stack[SW'(free_cnt)] <= head_q;
    head_q  <= lvl_head[scan_lv];
    tail_q  <= lvl_tail[((state == lobm_pkg::ST_REST) || (state == lobm_pkg::ST_PLACE)) ?
                        own_lv : scan_lv];
    owner_q <= slot_owner[head_q];
    qty_q   <= slot_qty[head_q];
    link_q  <= slot_link[head_q];
    stack_q <= free_stack[pop_idx];
  end

  // Control and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lobm_pkg::ST_IDLE;
      out_valid <= 1'b0;
      have_pend <= 1'b0;
      nonempty  <= '0;
      free_cnt  <= (SW + 1)'(ORDER_SLOTS);
      low_mark  <= (SW + 1)'(ORDER_SLOTS);
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        lobm_pkg::ST_IDLE: begin
          have_pend <= 1'b0;
          res_code  <= lobm_pkg::OUT_ZERO;
          if (item_valid) begin
            cur   <= item;
            rem   <= item.qty;
            chunk <= item.side ? CW'(NCH - 1) : '0;
          end
        end
        lobm_pkg::ST_SCAN: begin
          lv_hit <= scan_lv;
          t_hit  <= 8'(int'(chunk) * CH + int'(off_hit));
          if (!found && !last_chunk) begin
            chunk <= cur.side ? chunk - 1'b1 : chunk + 1'b1;
          end
        end
        lobm_pkg::ST_SLOT: begin
          if (step_ok) begin
            if (have_pend) begin
              out_data  <= pend;
            end
            pend      <= trade;
            have_pend <= 1'b1;
            rem       <= rem_new;
            res_code  <= lobm_pkg::OUT_FILLED;
            if (qty_new == '0) begin
              if (push_we) free_cnt <= free_cnt + 1'b1;
              if (head_q == tail_q) nonempty[lv_hit] <= 1'b0;
            end
          end
        end
        lobm_pkg::ST_REST: begin
          if (free_cnt == '0) res_code <= lobm_pkg::OUT_REJECTED;
        end
        lobm_pkg::ST_PLACE: begin
          res_code         <= lobm_pkg::OUT_RESTED;
          new_slot         <= pop_slot;
          nonempty[own_lv] <= 1'b1;
          free_cnt         <= free_cnt - 1'b1;
          if ({1'b0, pop_idx} < low_mark) low_mark <= {1'b0, pop_idx};
        end
        lobm_pkg::ST_DONE: begin
          if (out_free) begin
            out_data  <= final_res;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
